// ----- sv/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Shared sizes, codes, item types and conversion helpers.
// ----------------------------------------------------------------------------
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(DATA_WIDTH);
   localparam int VALUE_W     = 32;
   localparam int RSP_DEPTH_W = 5;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      ACT_PUSH,
      ACT_DROP,
      ACT_ADD,
      ACT_SUB,
      ACT_MUL,
      ACT_DIV
   } action_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_UNDERFLOW,
      ST_OVERFLOW,
      ST_DIV_ZERO
   } status_type;

   typedef enum logic [1:0] {
      CALC_IDLE,
      CALC_EXEC,
      CALC_DIVIDE,
      CALC_COMMIT
   } calc_state_type;

   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quotient;
   } div_rsp_type;

   function automatic word_type to_word(input logic [VALUE_W-1:0] value);
      logic [DATA_WIDTH+VALUE_W-1:0] wide;
      wide = {{DATA_WIDTH{1'b0}}, value};
      return wide[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] to_value(input word_type word);
      logic [DATA_WIDTH+VALUE_W-1:0] wide;
      wide = {{VALUE_W{1'b0}}, word};
      return wide[VALUE_W-1:0];
   endfunction

   function automatic logic [RSP_DEPTH_W-1:0] to_rsp_depth(input logic [DEPTH_W-1:0] depth);
      logic [DEPTH_W+RSP_DEPTH_W-1:0] wide;
      wide = {{RSP_DEPTH_W{1'b0}}, depth};
      return wide[RSP_DEPTH_W-1:0];
   endfunction

endpackage

// ----- sv/rpn_req_if.sv -----
// ----------------------------------------------------------------------------
// RPN request channel
// Carries one action item with its push value.
// ----------------------------------------------------------------------------
interface rpn_req_if;
   logic                                valid;
   logic                                ready;
   rpn_pkg::action_type                 action;
   logic signed [rpn_pkg::VALUE_W-1:0]  push_value;

   modport source(output valid, output action, output push_value, input ready);
   modport sink(input valid, input action, input push_value, output ready);
endinterface

// ----- sv/rpn_rsp_if.sv -----
// ----------------------------------------------------------------------------
// RPN response channel
// Carries the top value, depth and status after each item.
// ----------------------------------------------------------------------------
interface rpn_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rpn_pkg::VALUE_W-1:0]     top_value;
   logic [rpn_pkg::RSP_DEPTH_W-1:0]        stack_depth;
   rpn_pkg::status_type                    status;

   modport source(output valid, output top_value, output stack_depth, output status,
                  input ready);
   modport sink(input valid, input top_value, input stack_depth, input status,
                output ready);
endinterface

// ----- sv/rpn_divider.sv -----
// ----------------------------------------------------------------------------
// RPN divider
// Signed truncating division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rpn_pkg::div_req_type div_req,
   output rpn_pkg::div_rsp_type div_rsp
);
   import rpn_pkg::*;

   logic               run_ff;
   logic               fix_ff;
   logic               done_ff;
   logic [COUNT_W-1:0] count_ff;
   word_type           rem_ff;
   word_type           quo_ff;
   word_type           dvs_ff;
   logic               neg_ff;
   word_type           quot_ff;

   logic [DATA_WIDTH:0] shifted;
   logic [DATA_WIDTH:0] trial;
   logic                last_step;

   function automatic word_type magnitude(input word_type value);
      return value[DATA_WIDTH-1] ? word_type'(0) - value : value;
   endfunction

   assign shifted   = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign trial     = shifted - {1'b0, dvs_ff};
   assign last_step = run_ff && (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fix_ff;
         fix_ff  <= last_step;
         if (div_req.start) begin
            run_ff <= 1'b1;
         end else if (last_step) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff   <= '0;
         quo_ff   <= magnitude(div_req.dividend);
         dvs_ff   <= magnitude(div_req.divisor);
         neg_ff   <= div_req.dividend[DATA_WIDTH-1] ^ div_req.divisor[DATA_WIDTH-1];
         count_ff <= COUNT_W'(DATA_WIDTH - 1);
      end else if (run_ff) begin
         if (!trial[DATA_WIDTH]) begin
            rem_ff <= trial[DATA_WIDTH-1:0];
         end else begin
            rem_ff <= shifted[DATA_WIDTH-1:0];
         end
         quo_ff   <= {quo_ff[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
         count_ff <= count_ff - COUNT_W'(1);
      end
      if (fix_ff) begin
         quot_ff <= neg_ff ? word_type'(0) - quo_ff : quo_ff;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// ----- sv/rpn_stack_calculator.sv -----
// ----------------------------------------------------------------------------
// RPN stack calculator
// Integer reverse-Polish stack engine with a memory-held operand stack.
// ----------------------------------------------------------------------------
// One item is handled at a time. Push, drop, add, subtract, multiply, an
// ignored action code and any item that ends in an error pass from
// acceptance to the next acceptance through stack memory read, execute and
// commit, and commit waits while the output register holds an untaken result;
// divide also waits for the divider, which produces one quotient bit per cycle.
// The top entry is held in a register and the entry below it is read from
// the stack memory, so the next item can be accepted while a result still
// waits in the output register. No clearing pass is needed after reset.
module rpn_stack_calculator (
   input  logic      clock,
   input  logic      reset,
   rpn_req_if.sink   req_if,
   rpn_rsp_if.source rsp_if
);
   import rpn_pkg::*;

   calc_state_type     state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff;
   word_type           top_ff;
   logic               rsp_valid_ff;

   action_type         act_ff;
   logic [VALUE_W-1:0] value_ff;

   word_type           stack_mem [STACK_DEPTH];
   word_type           rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;

   status_type         pend_status_ff, pend_status_in;
   logic [DEPTH_W-1:0] pend_depth_ff, pend_depth_in;
   logic               pend_we_ff, pend_we_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   word_type           pend_top_ff, pend_top_in;

   logic [VALUE_W-1:0]     rsp_top_ff;
   logic [RSP_DEPTH_W-1:0] rsp_depth_ff;
   status_type             rsp_status_ff;

   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               div_start;

   logic [DEPTH_W-1:0] depth_m1;
   logic [DEPTH_W-1:0] depth_m2;
   logic               has_two;
   logic               out_free;
   logic               commit_fire;
   logic               accept;
   word_type           mul_res;

   assign depth_m1    = depth_ff - DEPTH_W'(1);
   assign depth_m2    = depth_ff - DEPTH_W'(2);
   assign has_two     = depth_ff >= DEPTH_W'(2);
   assign rd_addr     = depth_m2[ADDR_W-1:0];
   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign commit_fire = (state_ff == CALC_COMMIT) && out_free;
   assign accept      = req_if.valid && req_if.ready;
   assign mul_res     = rd_data_ff * top_ff;

   assign req_if.ready = (state_ff == CALC_IDLE);

   assign div_req.start    = div_start;
   assign div_req.dividend = rd_data_ff;
   assign div_req.divisor  = top_ff;

   rpn_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      pend_status_in = pend_status_ff;
      pend_depth_in  = pend_depth_ff;
      pend_we_in     = pend_we_ff;
      pend_addr_in   = pend_addr_ff;
      pend_top_in    = pend_top_ff;
      div_start      = 1'b0;
      unique case (state_ff)
         CALC_IDLE: begin
            if (req_if.valid) begin
               state_in = CALC_EXEC;
            end
         end
         CALC_EXEC: begin
            state_in       = CALC_COMMIT;
            pend_status_in = ST_OK;
            pend_depth_in  = depth_ff;
            pend_we_in     = 1'b0;
            pend_addr_in   = depth_m2[ADDR_W-1:0];
            pend_top_in    = top_ff;
            unique case (act_ff)
               ACT_PUSH: begin
                  if (depth_ff == DEPTH_W'(STACK_DEPTH)) begin
                     pend_status_in = ST_OVERFLOW;
                  end else begin
                     pend_we_in    = 1'b1;
                     pend_addr_in  = depth_ff[ADDR_W-1:0];
                     pend_depth_in = depth_ff + DEPTH_W'(1);
                     pend_top_in   = to_word(value_ff);
                  end
               end
               ACT_DROP: begin
                  if (depth_ff == '0) begin
                     pend_status_in = ST_UNDERFLOW;
                  end else begin
                     pend_depth_in = depth_m1;
                     pend_top_in   = has_two ? rd_data_ff : '0;
                  end
               end
               ACT_ADD, ACT_SUB, ACT_MUL: begin
                  if (!has_two) begin
                     pend_status_in = ST_UNDERFLOW;
                  end else begin
                     pend_we_in    = 1'b1;
                     pend_depth_in = depth_m1;
                     unique case (act_ff)
                        ACT_ADD: pend_top_in = rd_data_ff + top_ff;
                        ACT_SUB: pend_top_in = rd_data_ff - top_ff;
                        default: pend_top_in = mul_res;
                     endcase
                  end
               end
               ACT_DIV: begin
                  if (!has_two) begin
                     pend_status_in = ST_UNDERFLOW;
                  end else if (top_ff == '0) begin
                     pend_status_in = ST_DIV_ZERO;
                  end else begin
                     pend_we_in    = 1'b1;
                     pend_depth_in = depth_m1;
                     div_start     = 1'b1;
                     state_in      = CALC_DIVIDE;
                  end
               end
               default: begin
               end
            endcase
         end
         CALC_DIVIDE: begin
            if (div_rsp.done) begin
               pend_top_in = div_rsp.quotient;
               state_in    = CALC_COMMIT;
            end
         end
         CALC_COMMIT: begin
            if (out_free) begin
               state_in = CALC_IDLE;
            end
         end
         default: begin
            state_in = CALC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CALC_IDLE;
         depth_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit_fire) begin
            depth_ff     <= pend_depth_ff;
            top_ff       <= pend_top_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_if.action;
         value_ff <= req_if.push_value;
      end
      pend_status_ff <= pend_status_in;
      pend_depth_ff  <= pend_depth_in;
      pend_we_ff     <= pend_we_in;
      pend_addr_ff   <= pend_addr_in;
      pend_top_ff    <= pend_top_in;
      if (commit_fire) begin
         rsp_top_ff    <= to_value(pend_top_ff);
         rsp_depth_ff  <= to_rsp_depth(pend_depth_ff);
         rsp_status_ff <= pend_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_fire && pend_we_ff) begin
         stack_mem[pend_addr_ff] <= pend_top_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.top_value   = rsp_top_ff;
   assign rsp_if.stack_depth = rsp_depth_ff;
   assign rsp_if.status      = rsp_status_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("Stack depth exceeds the stack size.");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == CALC_EXEC))
      else $error("Accepted item did not move to execution.");

   assert property (@(posedge clock) disable iff (reset)
      (commit_fire && (pend_status_ff != ST_OK)) |=> (depth_ff == $past(depth_ff)))
      else $error("Failed item changed the stack depth.");

   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == CALC_DIVIDE))
      else $error("Divider finished outside a divide item.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.stack_depth == to_rsp_depth(depth_ff)))
      else $error("Reported depth differs from the stack depth.");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Drives push, drop, arithmetic and ignored action items into the calculator
// and checks every response against an internal model of the operand stack.
// A short scripted sequence covers the extremes and each error status. It is
// followed by randomised item streams that fill, drain and churn the stack.
// Random idling is applied on both channels, with one long response stall.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rpn_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam int QUIET_ITEMS  = 200;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SCRIPT_ROWS  = 22;

   localparam logic [2:0] ACT_IGNORED_6 = 3'd6;
   localparam logic [2:0] ACT_IGNORED_7 = 3'd7;

   typedef struct packed {
      logic signed [VALUE_W-1:0] top;
      logic [RSP_DEPTH_W-1:0]    depth;
      status_type                status;
   } calc_result_type;

   typedef struct {
      logic [2:0]      code;
      word_type        value;
      int              reps;
      bit              fixed;
      calc_result_type want;
   } script_row_type;

   logic clock;
   logic reset;

   rpn_req_if req ();
   rpn_rsp_if rsp ();

   rpn_stack_calculator DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req),
      .rsp_if(rsp)
   );

   word_type        model_stack [STACK_DEPTH];
   int              model_depth;
   calc_result_type pending_results[$];
   int              mismatch_count;
   int              cycle_count;
   bit              quiet_phase;
   bit              hold_request;
   bit              hold_done;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic calc_result_type apply_action(input logic [2:0] code,
                                                    input word_type value);
      calc_result_type res;
      word_type        lhs;
      word_type        rhs;
      word_type        outcome;
      longint          quo;
      res.status = ST_OK;
      outcome    = '0;
      case (code)
         ACT_PUSH: begin
            if (model_depth >= STACK_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               model_stack[model_depth] = value;
               model_depth++;
            end
         end
         ACT_DROP: begin
            if (model_depth == 0) res.status = ST_UNDERFLOW;
            else model_depth--;
         end
         ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
            if (model_depth < 2) begin
               res.status = ST_UNDERFLOW;
            end else begin
               lhs = model_stack[model_depth-2];
               rhs = model_stack[model_depth-1];
               if (code == ACT_DIV && rhs == '0) begin
                  res.status = ST_DIV_ZERO;
               end else begin
                  case (code)
                     ACT_ADD: outcome = lhs + rhs;
                     ACT_SUB: outcome = lhs - rhs;
                     ACT_MUL: outcome = lhs * rhs;
                     default: begin
                        quo     = longint'(signed'(lhs)) / longint'(signed'(rhs));
                        outcome = quo[DATA_WIDTH-1:0];
                     end
                  endcase
                  model_depth--;
                  model_stack[model_depth-1] = outcome;
               end
            end
         end
         default: ;
      endcase
      res.top   = (model_depth != 0) ? model_stack[model_depth-1] : '0;
      res.depth = RSP_DEPTH_W'(model_depth);
      return res;
   endfunction

   function automatic void queue_result(input calc_result_type res);
      pending_results.insert(pending_results.size(), res);
   endfunction

   function automatic word_type pick_operand();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return word_type'(1);
               2: return '1;
               3: return 32'h7FFF_FFFF;
               default: return 32'h8000_0000;
            endcase
         end
         1, 2, 3: return word_type'(int'($urandom_range(0, 16)) - 8);
         default: return $urandom;
      endcase
   endfunction

   task automatic offer_item(input logic [2:0] code, input word_type value);
      req.valid      <= 1'b1;
      req.action     <= action_type'(code);
      req.push_value <= value;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic sender_idle();
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** rpn_stack_calculator: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      calc_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: top_value %0d, stack_depth %0d, status %s",
                   rsp.top_value, rsp.stack_depth, rsp.status.name());
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp.top_value !== want.top) begin
               $error("top_value: expected %0d, actual %0d", want.top, rsp.top_value);
               mismatch_count++;
            end
            if (rsp.stack_depth !== want.depth) begin
               $error("stack_depth: expected %0d, actual %0d", want.depth, rsp.stack_depth);
               mismatch_count++;
            end
            if (rsp.status !== want.status) begin
               $error("status: expected %s, actual %s", want.status.name(), rsp.status.name());
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      hold_done = 1'b0;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request && !hold_done) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 2) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      script_row_type  script [SCRIPT_ROWS];
      calc_result_type predicted;
      logic [2:0]      code;
      word_type        value;
      int              sent_count;
      int              mode;
      int              push_share;
      int              roll;

      script = '{
         '{ACT_DROP,      '0,           1,  1, '{'0, 5'd0, ST_UNDERFLOW}},
         '{ACT_ADD,       '0,           1,  1, '{'0, 5'd0, ST_UNDERFLOW}},
         '{ACT_PUSH,      32'h7FFF_FFFF, 1, 1, '{32'h7FFF_FFFF, 5'd1, ST_OK}},
         '{ACT_SUB,       '0,           1,  1, '{32'h7FFF_FFFF, 5'd1, ST_UNDERFLOW}},
         '{ACT_PUSH,      32'h8000_0000, 1, 1, '{32'h8000_0000, 5'd2, ST_OK}},
         '{ACT_ADD,       '0,           1,  0, '{'0, 5'd0, ST_OK}},
         '{ACT_PUSH,      '1,           1,  0, '{'0, 5'd0, ST_OK}},
         '{ACT_MUL,       '0,           1,  0, '{'0, 5'd0, ST_OK}},
         '{ACT_PUSH,      '0,           1,  1, '{'0, 5'd2, ST_OK}},
         '{ACT_DIV,       '0,           1,  1, '{'0, 5'd2, ST_DIV_ZERO}},
         '{ACT_DROP,      '0,           1,  0, '{'0, 5'd0, ST_OK}},
         '{ACT_PUSH,      32'h8000_0000, 1, 0, '{'0, 5'd0, ST_OK}},
         '{ACT_PUSH,      '1,           1,  0, '{'0, 5'd0, ST_OK}},
         '{ACT_DIV,       '0,           1,  1, '{32'h8000_0000, 5'd2, ST_OK}},
         '{ACT_PUSH,      32'hFFFF_FFF9, 1, 0, '{'0, 5'd0, ST_OK}},
         '{ACT_PUSH,      32'h0000_0002, 1, 0, '{'0, 5'd0, ST_OK}},
         '{ACT_DIV,       '0,           1,  0, '{'0, 5'd0, ST_OK}},
         '{ACT_SUB,       '0,           1,  0, '{'0, 5'd0, ST_OK}},
         '{ACT_IGNORED_6, 32'h1234_5678, 1, 0, '{'0, 5'd0, ST_OK}},
         '{ACT_IGNORED_7, 32'hFFFF_FFFF, 1, 0, '{'0, 5'd0, ST_OK}},
         '{ACT_PUSH,      32'h5A5A_5A5A, 14, 0, '{'0, 5'd0, ST_OK}},
         '{ACT_PUSH,      32'hA5A5_A5A5, 1, 1, '{32'h5A5A_5A5A, 5'd16, ST_OVERFLOW}}
      };

      reset          <= 1'b1;
      req.valid      <= 1'b0;
      req.action     <= ACT_PUSH;
      req.push_value <= '0;
      quiet_phase    = 1'b0;
      hold_request   = 1'b0;
      model_depth    = 0;
      foreach (model_stack[i]) model_stack[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[r]) begin
         repeat (script[r].reps) begin
            sender_idle();
            offer_item(script[r].code, script[r].value);
            predicted = apply_action(script[r].code, script[r].value);
            queue_result(script[r].fixed ? script[r].want : predicted);
         end
      end

      sent_count = 0;
      mode       = 0;
      while (sent_count < RANDOM_ITEMS) begin
         if (sent_count == 600) hold_request = 1'b1;
         if (sent_count == 1200) begin
            req.valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         quiet_phase = (sent_count >= RANDOM_ITEMS - QUIET_ITEMS);
         if ($urandom_range(0, 39) == 0) mode = $urandom_range(0, 2);
         push_share = (mode == 0) ? 50 : (mode == 1) ? 85 : 20;
         roll       = $urandom_range(0, 99);
         value      = pick_operand();
         if (roll < 3) begin
            code = ($urandom_range(0, 1) != 0) ? ACT_IGNORED_6 : ACT_IGNORED_7;
         end else if (roll < push_share) begin
            code = ACT_PUSH;
         end else if (roll < push_share + (100 - push_share) / 5) begin
            code = ACT_DROP;
         end else begin
            case ($urandom_range(0, 3))
               0: code = ACT_ADD;
               1: code = ACT_SUB;
               2: code = ACT_MUL;
               default: code = ACT_DIV;
            endcase
         end
         sender_idle();
         offer_item(code, value);
         queue_result(apply_action(code, value));
         if (code != ACT_IGNORED_6 && code != ACT_IGNORED_7) sent_count++;
      end

      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("** rpn_stack_calculator: PASSED **");
      end else begin
         $display("** rpn_stack_calculator: FAILED **");
      end
      $finish;
   end

endmodule
